// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the stable min priority queue.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clk edge outside reset
`define CHK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition implies a property in the next cycle
`define CHK_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== sv/smpq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the stable min priority queue.
// No dependencies.
package smpq_pkg;

	localparam int HANDLE_W = 32;
	localparam int PRIO_W   = 16;
	localparam int OCC_W    = 5;
	localparam int OP_W     = 2;

	localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
	localparam logic [OP_W-1:0] OP_PULL   = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	typedef struct packed {
		logic push;
		logic pull;
		logic mark;
		logic remove;
	} cell_ctl_t;

endpackage

// ===== sv/stable_min_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// Stable min priority queue: sorted row of entry cells with FIFO order among equal priorities.
// Depends on smpq_pkg, smpq_cell and assert_macros.svh.
//
//   channel | signals                                  | direction
//   cmd     | cmd_valid cmd_ready operation handle prio | in
//   rsp     | rsp_valid rsp_ready out_handle out_valid  | out
//           |   overflow occupancy                      |
//
// Push, pull and no-op complete at the accepting edge.
// Remove first has the cells latch their handle compare, then shift; no command is taken in between.
// A new transaction is taken when no remove is pending and the response register is empty or drains that cycle.
// Reset empties the queue; cell contents are not cleared.
module stable_min_priority_queue_unit #(
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  logic [smpq_pkg::OP_W-1:0]           operation,
	input  logic [smpq_pkg::HANDLE_W-1:0]       handle,
	input  logic signed [smpq_pkg::PRIO_W-1:0]  prio,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic [smpq_pkg::HANDLE_W-1:0]       out_handle,
	output logic                                out_valid,
	output logic                                overflow,
	output logic [smpq_pkg::OCC_W-1:0]          occupancy
);

	`include "assert_macros.svh"

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]                 cnt_q;
	logic                             rm_pend_q;
	logic                             rsp_valid_q;
	logic [smpq_pkg::HANDLE_W-1:0]    out_handle_q;
	logic                             out_valid_q;
	logic                             overflow_q;

	logic                             cmd_fire;
	logic                             full;
	logic                             empty;
	logic                             do_push;
	logic                             do_pull;
	smpq_pkg::cell_ctl_t              ctl;

	logic [DEPTH-1:0]                 occ;
	logic [DEPTH-1:0]                 gt;
	logic [DEPTH-1:0]                 match;
	logic [DEPTH-1:0]                 above;
	logic                             any_match;
	logic [smpq_pkg::HANDLE_W-1:0]    cell_handle [DEPTH];
	logic signed [smpq_pkg::PRIO_W-1:0] cell_prio [DEPTH];

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign cmd_ready = !rm_pend_q && (!rsp_valid_q || rsp_ready);
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign do_push   = cmd_fire && (operation == smpq_pkg::OP_PUSH) && !full;
	assign do_pull   = cmd_fire && (operation == smpq_pkg::OP_PULL) && !empty;

	assign ctl.push   = do_push;
	assign ctl.pull   = do_pull;
	assign ctl.mark   = cmd_fire && (operation == smpq_pkg::OP_REMOVE);
	assign ctl.remove = rm_pend_q;

	assign any_match = |match;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			above[i] = |(match >> (i + 1));
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                               l_gt;
		logic [smpq_pkg::HANDLE_W-1:0]      l_handle;
		logic signed [smpq_pkg::PRIO_W-1:0] l_prio;
		logic [smpq_pkg::HANDLE_W-1:0]      r_handle;
		logic signed [smpq_pkg::PRIO_W-1:0] r_prio;

		assign occ[i] = (cnt_q > CNT_W'(i));

		if (i == 0) begin : g_first
			assign l_gt     = 1'b0;
			assign l_handle = '0;
			assign l_prio   = '0;
		end else begin : g_mid
			assign l_gt     = gt[i-1];
			assign l_handle = cell_handle[i-1];
			assign l_prio   = cell_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_handle = '0;
			assign r_prio   = '0;
		end else begin : g_inner
			assign r_handle = cell_handle[i+1];
			assign r_prio   = cell_prio[i+1];
		end

		smpq_cell u_cell (
			.clk          (clk),
			.ctl          (ctl),
			.occ          (occ[i]),
			.new_handle   (handle),
			.new_prio     (prio),
			.left_gt      (l_gt),
			.left_handle  (l_handle),
			.left_prio    (l_prio),
			.right_handle (r_handle),
			.right_prio   (r_prio),
			.any_match    (any_match),
			.above_match  (above[i]),
			.handle_q     (cell_handle[i]),
			.prio_q       (cell_prio[i]),
			.gt           (gt[i]),
			.match_q      (match[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rm_pend_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rm_pend_q) begin
				rm_pend_q   <= 1'b0;
				rsp_valid_q <= 1'b1;
				if (any_match) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end else if (cmd_fire) begin
				rm_pend_q   <= (operation == smpq_pkg::OP_REMOVE);
				rsp_valid_q <= (operation != smpq_pkg::OP_REMOVE);
				if (do_push) begin
					cnt_q <= cnt_q + 1'b1;
				end else if (do_pull) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rm_pend_q) begin
			out_handle_q <= '0;
			out_valid_q  <= any_match;
			overflow_q   <= 1'b0;
		end else if (cmd_fire) begin
			out_handle_q <= do_pull ? cell_handle[0] : '0;
			out_valid_q  <= do_pull;
			overflow_q   <= (operation == smpq_pkg::OP_PUSH) && full;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign out_handle = out_handle_q;
	assign out_valid  = out_valid_q;
	assign overflow   = overflow_q;
	assign occupancy  = smpq_pkg::OCC_W'(cnt_q);

	`CHK(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "entry count above depth")
	`CHK(a_rm_blocks, !(rm_pend_q && cmd_ready), "command taken during remove")
	`CHK_NEXT(a_rm_resp, rm_pend_q, rsp_valid_q, "remove finished without response")
	`CHK_NEXT(a_push_cnt, do_push, cnt_q == $past(cnt_q) + 1'b1, "push did not grow queue")
	`CHK(a_flags_excl, !(rsp_valid_q && out_valid_q && overflow_q), "valid and overflow together")

endmodule

// ===== sv/smpq_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the sorted queue row: holds an entry and shifts with its neighbors.
// Depends on smpq_pkg.
module smpq_cell (
	input  logic                                clk,
	input  smpq_pkg::cell_ctl_t                 ctl,
	input  logic                                occ,
	input  logic [smpq_pkg::HANDLE_W-1:0]       new_handle,
	input  logic signed [smpq_pkg::PRIO_W-1:0]  new_prio,
	input  logic                                left_gt,
	input  logic [smpq_pkg::HANDLE_W-1:0]       left_handle,
	input  logic signed [smpq_pkg::PRIO_W-1:0]  left_prio,
	input  logic [smpq_pkg::HANDLE_W-1:0]       right_handle,
	input  logic signed [smpq_pkg::PRIO_W-1:0]  right_prio,
	input  logic                                any_match,
	input  logic                                above_match,
	output logic [smpq_pkg::HANDLE_W-1:0]       handle_q,
	output logic signed [smpq_pkg::PRIO_W-1:0]  prio_q,
	output logic                                gt,
	output logic                                match_q
);

	assign gt = !occ || (prio_q > new_prio);

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			if (gt) begin
				if (left_gt) begin
					handle_q <= left_handle;
					prio_q   <= left_prio;
				end else begin
					handle_q <= new_handle;
					prio_q   <= new_prio;
				end
			end
		end else if (ctl.pull || (ctl.remove && any_match && !above_match)) begin
			handle_q <= right_handle;
			prio_q   <= right_prio;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mark) begin
			match_q <= occ && (handle_q == new_handle);
		end
	end

endmodule

// ===== test/tb_stable_min_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of stable_min_priority_queue_unit: random and directed
// push, pull and remove traffic checked against a sorted shadow queue. Depends on smpq_pkg and the DUT module.
module tb_stable_min_priority_queue_unit;
	import smpq_pkg::*;

	localparam int DEPTH = 16;
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_CMDS = 2000;
	localparam int CALM_TAIL = 150;
	localparam int TAIL_CYCLES = 8;
	localparam logic [OP_W-1:0] OP_IDLE = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [HANDLE_W-1:0] hdl;
		logic signed [PRIO_W-1:0] pr;
		logic drain;
	} cmd_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] hdl;
		logic hit;
		logic ovf;
		logic [OCC_W-1:0] occ;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	logic [OP_W-1:0] operation = '0;
	logic [HANDLE_W-1:0] handle = '0;
	logic signed [PRIO_W-1:0] prio = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [HANDLE_W-1:0] out_handle;
	logic out_valid;
	logic overflow;
	logic [OCC_W-1:0] occupancy;

	logic [HANDLE_W-1:0] shadow_handles [DEPTH];
	logic signed [PRIO_W-1:0] shadow_prios [DEPTH];
	int held = 0;

	cmd_t cmd_backlog [$];
	reply_t replies_due [$];
	int total_cmds = 0;
	int cmd_issued = 0;
	int cmd_taken = 0;
	int rsp_taken = 0;
	int mismatches = 0;
	int cycle_no = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int long_hold = 0;
	bit long_hold_done = 1'b0;
	bit send_bursty = 1'b1;
	bit recv_bursty = 1'b1;

	stable_min_priority_queue_unit #(.DEPTH(DEPTH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.operation(operation),
		.handle(handle),
		.prio(prio),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.out_handle(out_handle),
		.out_valid(out_valid),
		.overflow(overflow),
		.occupancy(occupancy)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic reply_t queue_op_reply(input logic [OP_W-1:0] op,
		input logic [HANDLE_W-1:0] hdl, input logic signed [PRIO_W-1:0] pr);
		reply_t r;
		int pos;
		int i;
		bit found;
		r = '0;
		found = 1'b0;
		case (op)
			OP_PUSH: begin
				if (held >= DEPTH) begin
					r.ovf = 1'b1;
				end else begin
					pos = 0;
					while (pos < held && shadow_prios[pos] <= pr)
						pos++;
					for (i = held; i > pos; i--) begin
						shadow_handles[i] = shadow_handles[i-1];
						shadow_prios[i] = shadow_prios[i-1];
					end
					shadow_handles[pos] = hdl;
					shadow_prios[pos] = pr;
					held++;
				end
			end
			OP_PULL: begin
				if (held > 0) begin
					r.hdl = shadow_handles[0];
					r.hit = 1'b1;
					for (i = 1; i < held; i++) begin
						shadow_handles[i-1] = shadow_handles[i];
						shadow_prios[i-1] = shadow_prios[i];
					end
					held--;
				end
			end
			OP_REMOVE: begin
				// scan from the back: largest priority, newest among ties
				for (i = held; i > 0 && !found; i--) begin
					if (shadow_handles[i-1] == hdl) begin
						for (pos = i; pos < held; pos++) begin
							shadow_handles[pos-1] = shadow_handles[pos];
							shadow_prios[pos-1] = shadow_prios[pos];
						end
						held--;
						r.hit = 1'b1;
						found = 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.occ = held[OCC_W-1:0];
		return r;
	endfunction

	function automatic bit calm();
		return cmd_taken + CALM_TAIL >= total_cmds;
	endfunction

	task automatic add_cmd(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] hdl,
		input logic signed [PRIO_W-1:0] pr);
		cmd_t c;
		c.op = op;
		c.hdl = hdl;
		c.pr = pr;
		c.drain = 1'b0;
		cmd_backlog.push_back(c);
	endtask

	// driver: present a new transaction once the previous one is taken
	always @(negedge clk) begin
		cmd_t nxt;
		logic go;
		if (arst_n && (!cmd_valid || cmd_taken == cmd_issued)) begin
			if (cycle_no % 256 == 0)
				send_bursty = $urandom_range(0, 2) != 0;
			go = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (!calm() && send_bursty && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(0, 11);
			end else if (cmd_backlog.size() != 0 &&
				(!cmd_backlog[0].drain || replies_due.size() == 0)) begin
				nxt = cmd_backlog.pop_front();
				go = 1'b1;
				cmd_issued++;
				operation <= nxt.op;
				handle <= nxt.hdl;
				prio <= nxt.pr;
			end
			cmd_valid <= go;
		end
	end

	// receiver: random stalls plus one long hold-off to back up the queue
	always @(negedge clk) begin
		logic nr;
		if (arst_n) begin
			if (cycle_no % 256 == 128)
				recv_bursty = $urandom_range(0, 2) != 0;
			nr = 1'b0;
			if (long_hold > 0) begin
				long_hold--;
			end else if (!long_hold_done && rsp_taken >= 500) begin
				long_hold_done = 1'b1;
				long_hold = 199;
			end else if (recv_gap > 0) begin
				recv_gap--;
			end else if (!calm() && recv_bursty && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 11);
			end else begin
				nr = 1'b1;
			end
			rsp_ready <= nr;
		end
	end

	// monitor: check the response first, then record the accepted transaction
	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			got = {out_handle, out_valid, overflow, occupancy};
			rsp_taken++;
			if (replies_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected rsp %0d: hdl %h vld %b ovf %b occ %0d",
						rsp_taken, got.hdl, got.hit, got.ovf, got.occ);
			end else begin
				want = replies_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("rsp %0d: exp %h/%b/%b/%0d got %h/%b/%b/%0d",
							rsp_taken, want.hdl, want.hit, want.ovf, want.occ,
							got.hdl, got.hit, got.ovf, got.occ);
				end
			end
		end
		if (arst_n && cmd_valid && cmd_ready) begin
			replies_due.push_back(queue_op_reply(operation, handle, prio));
			cmd_taken++;
		end
	end

	always @(posedge clk) begin
		cycle_no++;
		if (cycle_no > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [HANDLE_W-1:0] tag_pool [12];
		logic [HANDLE_W-1:0] hdl;
		logic signed [PRIO_W-1:0] pr;
		logic [OP_W-1:0] op;
		int made;
		int bias;
		int run_len;
		int r;
		int k;

		// empty-queue cases and the unused code
		add_cmd(OP_PULL, 32'h0000_0000, 16'sd0);
		add_cmd(OP_REMOVE, 32'h0000_1234, 16'sd0);
		add_cmd(OP_IDLE, 32'hFFFF_FFFF, -16'sd1);
		// fill past full with extremes, ties and repeated handles, then remove and pull
		add_cmd(OP_PUSH, 32'h0000_0000, -16'sd32768);
		add_cmd(OP_PUSH, 32'hFFFF_FFFF, 16'sd32767);
		add_cmd(OP_PUSH, 32'hA5A5_0001, 16'sd5);
		add_cmd(OP_PUSH, 32'hA5A5_0002, 16'sd5);
		add_cmd(OP_PUSH, 32'hA5A5_0003, 16'sd5);
		add_cmd(OP_PUSH, 32'hA5A5_0001, 16'sd5);
		add_cmd(OP_PUSH, 32'h5A5A_0004, -16'sd1);
		add_cmd(OP_PUSH, 32'h5A5A_0005, 16'sd0);
		add_cmd(OP_PUSH, 32'hA5A5_0001, 16'sd32767);
		add_cmd(OP_PUSH, 32'h5A5A_0006, -16'sd32768);
		add_cmd(OP_PUSH, 32'h5A5A_0007, 16'sd0);
		add_cmd(OP_PUSH, 32'h5A5A_0008, 16'sd5);
		add_cmd(OP_PUSH, 32'hA5A5_0002, -16'sd1);
		add_cmd(OP_PUSH, 32'h5A5A_0009, 16'sd100);
		add_cmd(OP_PUSH, 32'h5A5A_000A, -16'sd100);
		add_cmd(OP_PUSH, 32'h5A5A_000B, 16'sd7);
		add_cmd(OP_PUSH, 32'h5A5A_000C, 16'sd0);
		add_cmd(OP_REMOVE, 32'hA5A5_0001, 16'sd0);
		add_cmd(OP_REMOVE, 32'hA5A5_0001, 16'sd0);
		add_cmd(OP_REMOVE, 32'h5555_5555, 16'sd0);
		add_cmd(OP_PULL, 32'h0000_0000, 16'sd0);
		add_cmd(OP_PULL, 32'h0000_0000, 16'sd0);
		add_cmd(OP_PULL, 32'h0000_0000, 16'sd0);

		for (k = 0; k < 12; k++)
			tag_pool[k] = $urandom;
		made = 0;
		while (made < RANDOM_CMDS) begin
			// runs biased toward filling, draining, balanced or removing
			bias = $urandom_range(0, 3);
			run_len = $urandom_range(20, 60);
			for (k = 0; k < run_len && made < RANDOM_CMDS; k++) begin
				r = $urandom_range(0, 99);
				case (bias)
					0: op = r < 70 ? OP_PUSH : r < 85 ? OP_PULL : r < 97 ? OP_REMOVE : OP_IDLE;
					1: op = r < 20 ? OP_PUSH : r < 85 ? OP_PULL : r < 97 ? OP_REMOVE : OP_IDLE;
					2: op = r < 45 ? OP_PUSH : r < 75 ? OP_PULL : r < 97 ? OP_REMOVE : OP_IDLE;
					default: op = r < 40 ? OP_PUSH : r < 50 ? OP_PULL : r < 97 ? OP_REMOVE : OP_IDLE;
				endcase
				hdl = $urandom_range(0, 9) == 0 ? $urandom : tag_pool[$urandom_range(0, 11)];
				if ($urandom_range(0, 4) == 0)
					pr = PRIO_W'($urandom);
				else
					pr = PRIO_W'($urandom_range(0, 7) - 4);
				add_cmd(op, hdl, pr);
				made++;
			end
		end
		// hold the sender here until every response is in
		cmd_backlog[cmd_backlog.size() / 2].drain = 1'b1;
		total_cmds = cmd_backlog.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_taken < total_cmds)
			@(posedge clk);
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/smpq_pkg.sv
sv/smpq_cell.sv
sv/stable_min_priority_queue_unit.sv
test/tb_stable_min_priority_queue_unit.sv
